>>> src/contiguous_page_allocator_defines.svh
// ---------------------------------------------------------------------------
// Contiguous page allocator assertion macros
// Shorthand for the clocked, reset-qualified checks used by the checker.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cpa_pkg.sv
// ---------------------------------------------------------------------------
// Contiguous page allocator package
// Word types, flag encodings, register indexes and sequencer states.
// ---------------------------------------------------------------------------
package cpa_pkg;

  // Width of a page count and of the usable-pages register
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned BASE_W = 20;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CFG_W  = 20;

  // Reset values of the registers
  localparam logic [CNT_W-1:0]  USABLE_RST = 11'd1024;
  localparam logic [BASE_W-1:0] BASE_RST   = 20'd0;

  // Page flag bits
  localparam logic [1:0] FLAG_FREE  = 2'b00;
  localparam logic [1:0] FLAG_TAKEN = 2'b01;
  localparam logic [1:0] FLAG_LAST  = 2'b10;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic {
    REG_USABLE_PAGES = 1'b0,
    REG_BASE_PAGE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_ALLOC_MARK,
    ST_FREE_CHECK,
    ST_FREE_READ,
    ST_FREE_EVAL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic              success;
  } out_word_t;

endpackage

>>> src/cpa_flag_mem.sv
// ---------------------------------------------------------------------------
// Page flag memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module cpa_flag_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cpa_ctrl.sv
// ---------------------------------------------------------------------------
// Allocator sequencer
// Clearing pass, first-fit scan, run marking and free walk over the flags.
// ---------------------------------------------------------------------------
module cpa_ctrl
  import cpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned AW         = 10,
  parameter int unsigned IW         = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  // configuration view
  input  logic [CNT_W-1:0]  pages_i,
  input  logic [ADDR_W-1:0] start_i,
  // result towards the output register
  output logic              res_valid_o,
  output out_word_t         res_word_o,
  input  logic              res_ready_i,
  // flag memory
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [1:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [1:0]        mem_rdata_i
);

  localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_PAGES - 1);

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [IW-1:0]     issue_q, issue_d;
  logic [IW-1:0]     proc_q, proc_d;
  logic              rvalid_q, rvalid_d;
  logic [CNT_W-1:0]  run_q, run_d;
  logic [IW-1:0]     first_q, first_d;
  logic [IW-1:0]     hit_q, hit_d;
  logic [IW-1:0]     idx_q, idx_d;
  out_word_t         res_q, res_d;

  logic [IW-1:0]     pages_ext;
  logic [CNT_W-1:0]  run_inc;
  logic [ADDR_W+1:0] end_addr;
  logic [ADDR_W-1:0] addr_off;
  logic              in_range;

  assign pages_ext = IW'(pages_i);
  assign run_inc   = run_q + 1'b1;

  // Free address window: start up to start plus the managed pages
  assign end_addr = (ADDR_W+2)'(start_i) + ((ADDR_W+2)'(pages_i) << PAGE_SHIFT);
  assign addr_off = addr_q - start_i;
  assign in_range = (addr_q != '0) && (addr_q >= start_i)
                    && ((ADDR_W+2)'(addr_q) < end_addr);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      clr_q    <= clr_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    addr_q  <= addr_d;
    issue_q <= issue_d;
    proc_q  <= proc_d;
    run_q   <= run_d;
    first_q <= first_d;
    hit_q   <= hit_d;
    idx_q   <= idx_d;
    res_q   <= res_d;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    addr_d      = addr_q;
    issue_d     = issue_q;
    proc_d      = proc_q;
    rvalid_d    = rvalid_q;
    run_d       = run_q;
    first_d     = first_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    res_d       = res_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = clr_q;
    mem_wdata_o = FLAG_FREE;
    mem_re_o    = 1'b0;
    mem_raddr_o = issue_q[AW-1:0];

    unique case (state_q)
      // sweep every entry to free after reset
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        if (clr_q == LAST_ENTRY) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          count_d  = in_word_i.page_count;
          addr_d   = in_word_i.address;
          issue_d  = '0;
          run_d    = '0;
          rvalid_d = 1'b0;
          if (in_word_i.mode == MODE_FREE) begin
            state_d = ST_FREE_CHECK;
          end else if ((in_word_i.page_count != '0)
                       && (in_word_i.page_count <= pages_i)) begin
            state_d = ST_ALLOC_SCAN;
          end else begin
            res_d   = '{block_address: '0, success: 1'b0};
            state_d = ST_RESP;
          end
        end
      end

      // pipelined first-fit search: issue one read, judge the previous one
      ST_ALLOC_SCAN: begin
        if (rvalid_q && !mem_rdata_i[0] && (run_inc == count_q)) begin
          first_d  = proc_q + IW'(1) - IW'(count_q);
          idx_d    = proc_q + IW'(1) - IW'(count_q);
          hit_d    = proc_q;
          rvalid_d = 1'b0;
          state_d  = ST_ALLOC_MARK;
        end else if (rvalid_q && (proc_q == pages_ext - IW'(1))) begin
          rvalid_d = 1'b0;
          res_d    = '{block_address: '0, success: 1'b0};
          state_d  = ST_RESP;
        end else begin
          if (rvalid_q) begin
            run_d = mem_rdata_i[0] ? '0 : run_inc;
          end
          if (issue_q < pages_ext) begin
            mem_re_o = 1'b1;
            rvalid_d = 1'b1;
            proc_d   = issue_q;
            issue_d  = issue_q + 1'b1;
          end else begin
            rvalid_d = 1'b0;
          end
        end
      end

      // mark the found run taken, last flag on its final page
      ST_ALLOC_MARK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        if (idx_q == hit_q) begin
          mem_wdata_o = FLAG_TAKEN | FLAG_LAST;
          res_d       = '{block_address: start_i + (ADDR_W'(first_q) << PAGE_SHIFT),
                          success: 1'b1};
          state_d     = ST_RESP;
        end else begin
          mem_wdata_o = FLAG_TAKEN;
          idx_d       = idx_q + 1'b1;
        end
      end

      ST_FREE_CHECK: begin
        if (in_range) begin
          idx_d   = IW'(addr_off >> PAGE_SHIFT);
          res_d   = '{block_address: '0, success: 1'b1};
          state_d = ST_FREE_READ;
        end else begin
          res_d   = '{block_address: '0, success: 1'b0};
          state_d = ST_RESP;
        end
      end

      ST_FREE_READ: begin
        mem_raddr_o = idx_q[AW-1:0];
        if (idx_q < pages_ext) begin
          mem_re_o = 1'b1;
          state_d  = ST_FREE_EVAL;
        end else begin
          state_d  = ST_RESP;
        end
      end

      // clear a taken page; stop on a last page or a free one
      ST_FREE_EVAL: begin
        mem_waddr_o = idx_q[AW-1:0];
        if (mem_rdata_i[0]) begin
          mem_we_o = 1'b1;
          if (mem_rdata_i[1]) begin
            state_d = ST_RESP;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_FREE_READ;
          end
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_word_o = res_q;

endmodule

>>> src/contiguous_page_allocator.sv
// ---------------------------------------------------------------------------
// Contiguous page allocator (first fit)
// Allocate: a first-fit scan reads one flag entry per cycle, then the found
//   run is marked taken; a miss or a bad count gives a failed reply.
// Free: each flag entry visited is read, then written back, until a last page,
//   a free page or the window end; a rejected address gives a failed reply.
// One word at a time: the next word is taken the cycle after a result leaves.
// After reset a clearing pass over all MAX_PAGES entries runs before input is taken.
// ---------------------------------------------------------------------------
module contiguous_page_allocator
  import cpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // input words
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  // output words
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o
);

  localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned IW = (AW >= CNT_W) ? AW + 1 : CNT_W;

  logic [CNT_W-1:0]  usable_q;
  logic [BASE_W-1:0] base_q;
  logic [CNT_W-1:0]  pages;
  logic [ADDR_W-1:0] start_addr;

  logic              res_valid;
  logic              res_ready;
  out_word_t         res_word;
  logic              out_valid_q;
  out_word_t         out_word_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [1:0]        mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [1:0]        mem_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= USABLE_RST;
      base_q   <= BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_USABLE_PAGES: usable_q <= cfg_wdata_i[CNT_W-1:0];
        REG_BASE_PAGE:    base_q   <= cfg_wdata_i[BASE_W-1:0];
        default:          usable_q <= usable_q;
      endcase
    end
  end

  // Managed page count, clamped to the flag store
  assign pages = (32'(usable_q) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : usable_q;
  assign start_addr = ADDR_W'(base_q) << PAGE_SHIFT;

  cpa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .AW         (AW),
    .IW         (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .pages_i     (pages),
    .start_i     (start_addr),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cpa_flag_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (AW)
  ) u_flag_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a result when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> src/cpa_checker.sv
// ---------------------------------------------------------------------------
// Contiguous page allocator checker
// Port-level checks on the word channels, bound to the top level.
// ---------------------------------------------------------------------------
`include "contiguous_page_allocator_defines.svh"

module cpa_checker
  import cpa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a held result stays offered
  `CPA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "out dropped")

  // a held result keeps its word
  `CPA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_word_o), "out word moved")

  // failures never carry an address
  `CPA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid_o && !out_word_o.success, out_word_o.block_address == '0, "failed word has address")

  // one word at a time: the block is busy right after taking a word
  `CPA_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second word taken while busy")

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

>>> sim/tb_contiguous_page_allocator.sv
// ---------------------------------------------------------------------------
// Contiguous page allocator testbench
// Drives allocate and free words through the valid/stall channels and keeps
// its own copy of the page map. Every reply word is checked against the reply
// that this copy predicts. The run steps through several page ranges and base
// pages, including the extremes, under different idling patterns and one
// long stall on the reply channel.
// ---------------------------------------------------------------------------
module tb_contiguous_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import cpa_pkg::*;

  localparam int unsigned PAGES          = 1024;
  localparam int unsigned SHIFT          = 12;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned MAX_REPORTS    = 10;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic             cfg_idx   = REG_USABLE_PAGES;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;

  // Page map copy, register copies and the replies still owed by the block
  class page_map_tracker;
    logic [1:0]        flags [PAGES];
    logic [CNT_W-1:0]  usable;
    logic [BASE_W-1:0] base;
    out_word_t         pending_replies[$];
    logic [ADDR_W-1:0] live_blocks[$];
    int unsigned       errors;

    function new();
      foreach (flags[i]) flags[i] = FLAG_FREE;
      usable = USABLE_RST;
      base   = BASE_RST;
      errors = 0;
    endfunction

    function int unsigned eff_pages();
      return (usable > PAGES) ? PAGES : int'(usable);
    endfunction

    function logic [ADDR_W-1:0] start_addr();
      return ADDR_W'(base) << SHIFT;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
      if (idx == REG_USABLE_PAGES) usable = value[CNT_W-1:0];
      else base = value[BASE_W-1:0];
      // old addresses mean little once the window moves
      live_blocks.delete();
    endfunction

    // First-fit search on allocate, walk-and-clear on free
    function void note_request(in_word_t w);
      out_word_t         r;
      int unsigned       n;
      int unsigned       run;
      int unsigned       first;
      logic [ADDR_W-1:0] start;
      logic [63:0]       stop;
      logic [63:0]       a;
      logic [63:0]       idx;
      bit                last;
      n     = eff_pages();
      start = start_addr();
      r     = '0;
      if (w.mode == MODE_ALLOC) begin
        if (w.page_count != 0 && w.page_count <= n) begin
          run = 0;
          for (int unsigned i = 0; i < n; i++) begin
            if ((flags[i] & FLAG_TAKEN) != FLAG_FREE) begin
              run = 0;
            end else begin
              run++;
              if (run == w.page_count) begin
                first = i + 1 - run;
                for (int unsigned k = first; k <= i; k++) flags[k] |= FLAG_TAKEN;
                flags[i] |= FLAG_LAST;
                r.block_address = start + (ADDR_W'(first) << SHIFT);
                r.success       = 1'b1;
                live_blocks.push_back(r.block_address);
                break;
              end
            end
          end
        end
      end else begin
        a    = 64'(w.address);
        stop = 64'(start) + (64'(n) << SHIFT);
        if (a != 0 && a >= 64'(start) && a < stop) begin
          r.success = 1'b1;
          idx = (a - 64'(start)) >> SHIFT;
          // stops after a last page, at a free page or at the window's end
          while (idx < n && (flags[idx] & FLAG_TAKEN) != FLAG_FREE) begin
            last       = (flags[idx] & FLAG_LAST) != FLAG_FREE;
            flags[idx] = FLAG_FREE;
            if (last) break;
            idx++;
          end
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void report(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: reply word with none outstanding: address %h success %b",
                   $realtime, got.block_address, got.success);
        return;
      end
      want = pending_replies.pop_front();
      if (got.block_address !== want.block_address)
        report("block_address", want.block_address, got.block_address);
      if (got.success !== want.success)
        report("success", ADDR_W'(want.success), ADDR_W'(got.success));
    endfunction

    function bit clean();
      if (pending_replies.size() != 0)
        $display("%0d reply words never arrived", pending_replies.size());
      return errors == 0 && pending_replies.size() == 0;
    endfunction
  endclass

  page_map_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_go       = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  contiguous_page_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #6 clk_i = ~clk_i;

  // Reply side: check accepted words, then decide the stall for next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) tracker.check_reply(out_word);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** contiguous_page_allocator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t make_word(mode_e m, int unsigned cnt, logic [ADDR_W-1:0] addr);
    in_word_t w;
    w.mode       = m;
    w.page_count = CNT_W'(cnt);
    w.address    = addr;
    return w;
  endfunction

  // Mostly allocates of small runs and frees of live blocks, some noise
  function automatic in_word_t random_word();
    in_word_t          w;
    int unsigned       n;
    int unsigned       maxc;
    int unsigned       pick;
    int unsigned       sel;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] blk;
    n            = tracker.eff_pages();
    start        = tracker.start_addr();
    w.page_count = CNT_W'($urandom);
    w.address    = $urandom;
    pick         = $urandom_range(99);
    if (pick < 45) begin
      w.mode = MODE_ALLOC;
      maxc   = (n == 0) ? 1 : ((n < 8) ? n : 8);
      sel    = $urandom_range(99);
      if (sel < 82) begin
        w.page_count = CNT_W'($urandom_range(maxc, 1));
      end else if (sel < 90) begin
        w.page_count = CNT_W'($urandom_range(2047, 0));
      end else begin
        case ($urandom_range(2))
          0:       w.page_count = '0;
          1:       w.page_count = CNT_W'(n);
          default: w.page_count = CNT_W'(n + 1);
        endcase
      end
    end else if (pick < 85 && tracker.live_blocks.size() > 0) begin
      w.mode = MODE_FREE;
      sel    = $urandom_range(tracker.live_blocks.size() - 1);
      blk    = tracker.live_blocks[sel];
      tracker.live_blocks.delete(sel);
      // unaligned or mid-block frees now and then
      case ($urandom_range(3))
        0:       blk = blk + $urandom_range(4095);
        1:       blk = blk + ($urandom_range(2) << SHIFT);
        default: ;
      endcase
      w.address = blk;
    end else begin
      w.mode = MODE_FREE;
      case ($urandom_range(5))
        0: w.address = '0;
        1: w.address = start - 1;
        2: w.address = start + (ADDR_W'(n) << SHIFT);
        3: if (n > 0)
             w.address = start + (ADDR_W'($urandom_range(n - 1)) << SHIFT)
                         + $urandom_range(4095);
        default: ;
      endcase
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    tracker.note_request(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned pages, logic [BASE_W-1:0] base_pg,
                           int unsigned snd_idle, int unsigned rcv_stall,
                           int unsigned words, bit pressure);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_USABLE_PAGES;
    cfg_wdata <= CFG_W'(pages);
    @(posedge clk_i);
    tracker.write_reg(REG_USABLE_PAGES, CFG_W'(pages));
    cfg_idx   <= REG_BASE_PAGE;
    cfg_wdata <= CFG_W'(base_pg);
    @(posedge clk_i);
    tracker.write_reg(REG_BASE_PAGE, CFG_W'(base_pg));
    cfg_we        <= 1'b0;
    send_idle_pct  = snd_idle;
    stall_pct     <= rcv_stall;
    if (pressure) hold_go <= 1'b1;
    repeat (words) send_word(random_word());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset window: 1024 pages from address zero
    send_word(make_word(MODE_ALLOC, 1, '0));            // run at address zero
    send_word(make_word(MODE_FREE, 0, '0));             // zero address ignored
    send_word(make_word(MODE_ALLOC, 0, '1));            // zero count
    send_word(make_word(MODE_ALLOC, 1025, '0));         // count past the window
    send_word(make_word(MODE_ALLOC, 2047, '0));
    send_word(make_word(MODE_ALLOC, 3, '0));
    send_word(make_word(MODE_FREE, 2047, 32'h0000_1800)); // unaligned
    send_word(make_word(MODE_FREE, 0, 32'h0000_1000));  // already free
    send_word(make_word(MODE_ALLOC, 1024, '0));         // no room
    send_word(make_word(MODE_FREE, 0, 32'h0040_0000));  // at the end
    send_word(make_word(MODE_FREE, 0, 32'h003F_FFFF));
    send_word(make_word(MODE_FREE, 0, 32'h0000_0001));  // page zero, unaligned
    send_word(make_word(MODE_ALLOC, 1024, '0));         // whole window
    send_word(make_word(MODE_ALLOC, 1, '0));
    send_word(make_word(MODE_FREE, 0, 32'h0000_0FFF));  // walk to the last page
    send_word(make_word(MODE_ALLOC, 2, '0));
    send_word(make_word(MODE_ALLOC, 2, '0));
    send_word(make_word(MODE_FREE, 0, 32'h0000_3000));  // last page of a block
    send_word(make_word(MODE_FREE, 0, 32'h0000_2000));  // walk meets a free page
    send_word(make_word(MODE_ALLOC, 1, '1));
    send_word(make_word(MODE_FREE, 0, 32'hFFFF_FFFF));

    // Random phases over several windows and idling patterns
    run_phase(24,   20'h00100, 0,  0,  100, 1'b0);
    run_phase(48,   20'h12345, 86, 0,  90,  1'b0);
    run_phase(16,   20'hFFFFF, 0,  86, 90,  1'b0); // window wraps past 2^32
    run_phase(1,    20'h00000, 17, 17, 40,  1'b0);
    run_phase(0,    20'h00007, 17, 17, 20,  1'b0); // empty window
    run_phase(2047, 20'h80000, 0,  0,  60,  1'b0); // clipped to the page limit
    run_phase(32,   20'h00040, 0,  0,  80,  1'b1); // long reply stall
    run_phase(1024, 20'h00000, 17, 17, 80,  1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.clean())
      $display("** contiguous_page_allocator: PASSED **");
    else
      $display("** contiguous_page_allocator: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/cpa_pkg.sv
src/cpa_flag_mem.sv
src/cpa_ctrl.sv
src/contiguous_page_allocator.sv
src/cpa_checker.sv
sim/tb_contiguous_page_allocator.sv
